// File: rtl/pidaw_pkg.sv
// Package for the multichannel PID unit: payload types, lane gains, limits and register codes.
`default_nettype none

package pidaw_pkg;

  // Number of lanes carried by the payload structs.
  localparam int unsigned LANES_MAX = 5;

  // Cycles from the input register to a settled lane sum.
  localparam int unsigned LATENCY = 7;
  localparam int unsigned CNT_W = $clog2(LATENCY + 1);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_CHANNELS = 2'd0,
    CFG_SAMPLE_RATE_HZ  = 2'd1,
    CFG_HALF_PERIOD     = 2'd2
  } pidaw_cfg_idx_t;

  // Reset values of the configuration registers.
  localparam logic [2:0]  ACTIVE_RESET = 3'd5;
  localparam logic [19:0] RATE_RESET   = 20'd1000;
  localparam logic [31:0] HALF_RESET   = 32'd2147484;

  // Proportional gains, unsigned Q8.24.
  localparam logic [31:0] KP_Q24 [0:LANES_MAX-1] = '{
    32'd22369621, 32'd5592405, 32'd44739243, 32'd13981013, 32'd55924053
  };

  // Integral gains, unsigned Q8.24.
  localparam logic [31:0] KI_Q24 [0:LANES_MAX-1] = '{
    32'd1118481067, 32'd559240533, 32'd1677721600, 32'd314572800, 32'd167772160
  };

  // Derivative gains, unsigned Q0.32.
  localparam logic [31:0] KD_Q32 [0:LANES_MAX-1] = '{
    32'd128849019, 32'd143165577, 32'd300647711, 32'd58697886, 32'd322122547
  };

  // Integral clamp limits, Q16.16. Lane 0 shares the limit of lane 1.
  localparam logic [31:0] LIM_Q16 [0:LANES_MAX-1] = '{
    32'd218453333, 32'd218453333, 32'd655360000, 32'd122880000, 32'd65536
  };

  // One input beat: targets and predicted values, signed Q16.16.
  typedef struct packed {
    logic signed [31:0] target_0;
    logic signed [31:0] target_1;
    logic signed [31:0] target_2;
    logic signed [31:0] target_3;
    logic signed [31:0] target_4;
    logic signed [31:0] predicted_0;
    logic signed [31:0] predicted_1;
    logic signed [31:0] predicted_2;
    logic signed [31:0] predicted_3;
    logic signed [31:0] predicted_4;
  } pidaw_in_t;

  // One result beat: saturated drives, signed Q16.16.
  typedef struct packed {
    logic signed [31:0] drive_0;
    logic signed [31:0] drive_1;
    logic signed [31:0] drive_2;
    logic signed [31:0] drive_3;
    logic signed [31:0] drive_4;
  } pidaw_out_t;

  // Control from the sequencer to the lanes and the merge stage.
  typedef struct packed {
    logic       commit;
    logic [2:0] active;
  } pidaw_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/pidaw_lane.sv
// One PID lane: error, proportional, clamped trapezoidal integral and derivative terms.
`default_nettype none

module pidaw_lane import pidaw_pkg::*; #(
  parameter int unsigned LANE = 0
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pidaw_ctrl_t        ctrl,
  input  wire logic signed [31:0] target,
  input  wire logic signed [31:0] predicted,
  input  wire logic        [19:0] sample_rate_hz,
  input  wire logic        [31:0] half_period,
  output logic signed      [31:0] drive
);

  // Lane constants taken from the package tables.
  localparam logic signed [26:0] KP_S   = $signed({1'b0, KP_Q24[LANE][25:0]});
  localparam logic        [30:0] KI_U   = KI_Q24[LANE][30:0];
  localparam logic        [28:0] KD_U   = KD_Q32[LANE][28:0];
  localparam logic signed [40:0] LIM_P  = $signed({9'd0, LIM_Q16[LANE]});
  localparam logic signed [40:0] LIM_N  = -LIM_P;
  localparam logic        [74:0] DER_LIMIT = 75'd1 << 62;
  localparam logic signed [39:0] DER_POS = 40'sh40_0000_0000;
  localparam logic signed [39:0] DER_NEG = 40'shC0_0000_0000;

  // Lanes at or above the active count output zero and hold their state.
  logic on;
  assign on = (3'(LANE) < ctrl.active);

  // Per-lane state, cleared at reset.
  logic signed [31:0] prev_error_r;
  logic signed [31:0] integral_sum_r;

  // Pipeline registers; they settle from the held input register and state.
  logic signed [31:0] e_r,       e_nxt;
  logic        [62:0] kitp_r,    kitp_nxt;
  logic        [48:0] kdfp_r,    kdfp_nxt;
  logic signed [58:0] p_prod_r,  p_prod_nxt;
  logic signed [32:0] s_r,       s_nxt;
  logic signed [32:0] d_r,       d_nxt;
  logic        [30:0] ki_t_r,    ki_t_nxt;
  logic        [40:0] kd_f_r,    kd_f_nxt;
  logic signed [63:0] i_prod_r,  i_prod_nxt;
  logic        [32:0] ad_r,      ad_nxt;
  logic signed [34:0] p_r,       p_nxt;
  logic        [53:0] pp_lo_r,   pp_lo_nxt;
  logic        [52:0] pp_hi_r,   pp_hi_nxt;
  logic signed [40:0] i_raw_r,   i_raw_nxt;
  logic signed [31:0] integ_r,   integ_nxt;
  logic               ovf_r,     ovf_nxt;
  logic        [62:0] mag_r,     mag_nxt;
  logic signed [39:0] der_r,     der_nxt;
  logic signed [31:0] sum_r,     sum_nxt;

  // Intermediate values.
  logic signed [32:0] diff_w;
  logic        [63:0] ki_rnd_w;
  logic        [48:0] kd_rnd_w;
  logic signed [58:0] p_rnd_w;
  logic signed [63:0] i_rnd_w;
  logic        [74:0] m_w;
  logic signed [63:0] x_w;
  logic signed [63:0] der_rnd_w;
  logic signed [41:0] total_w;

  // Error with saturation, and the config-dependent gain products.
  always_comb begin
    diff_w = {target[31], target} - {predicted[31], predicted};
    if (diff_w[32] != diff_w[31]) begin
      e_nxt = diff_w[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      e_nxt = diff_w[31:0];
    end
    kitp_nxt = KI_U * half_period;
    kdfp_nxt = KD_U * sample_rate_hz;
  end

  // Proportional product, error sum and difference, rounded scaled gains.
  always_comb begin
    p_prod_nxt = e_r * KP_S;
    s_nxt      = 33'(e_r) + 33'(prev_error_r);
    d_nxt      = 33'(e_r) - 33'(prev_error_r);
    ki_rnd_w   = {1'b0, kitp_r} + 64'h8000_0000;
    ki_t_nxt   = ki_rnd_w[62:32];
    kd_rnd_w   = kdfp_r + 49'd128;
    kd_f_nxt   = kd_rnd_w[48:8];
  end

  // Integral product, derivative magnitude and rounded proportional term.
  always_comb begin
    i_prod_nxt = s_r * $signed({1'b0, ki_t_r});
    ad_nxt     = d_r[32] ? 33'(-d_r) : 33'(d_r);
    p_rnd_w    = p_prod_r + 59'sd8388608;
    p_nxt      = p_rnd_w[58:24];
  end

  // Derivative partial products and the unclamped integral.
  always_comb begin
    pp_lo_nxt = ad_r * kd_f_r[20:0];
    pp_hi_nxt = ad_r * kd_f_r[40:21];
    i_rnd_w   = i_prod_r + 64'sd8388608;
    i_raw_nxt = 41'(integral_sum_r) + 41'($signed(i_rnd_w[63:24]));
  end

  // Anti-windup clamp, derivative magnitude and overflow flag.
  always_comb begin
    if (i_raw_r > LIM_P) begin
      integ_nxt = LIM_P[31:0];
    end else if (i_raw_r < LIM_N) begin
      integ_nxt = LIM_N[31:0];
    end else begin
      integ_nxt = i_raw_r[31:0];
    end
    m_w     = 75'({pp_hi_r, 21'd0}) + 75'(pp_lo_r);
    ovf_nxt = (m_w > DER_LIMIT);
    mag_nxt = m_w[62:0];
  end

  // Signed, rounded derivative term, clamped to +/-2^38 on overflow.
  always_comb begin
    x_w       = d_r[32] ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
    der_rnd_w = x_w + 64'sd8388608;
    if (ovf_r) begin
      der_nxt = d_r[32] ? DER_NEG : DER_POS;
    end else begin
      der_nxt = der_rnd_w[63:24];
    end
  end

  // Saturated sum of the three terms.
  always_comb begin
    total_w = 42'(p_r) + 42'(integ_r) + 42'(der_r);
    if (total_w > 42'sd2147483647) begin
      sum_nxt = 32'sh7FFF_FFFF;
    end else if (total_w < -42'sd2147483648) begin
      sum_nxt = 32'sh8000_0000;
    end else begin
      sum_nxt = total_w[31:0];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    e_r      <= e_nxt;
    kitp_r   <= kitp_nxt;
    kdfp_r   <= kdfp_nxt;
    p_prod_r <= p_prod_nxt;
    s_r      <= s_nxt;
    d_r      <= d_nxt;
    ki_t_r   <= ki_t_nxt;
    kd_f_r   <= kd_f_nxt;
    i_prod_r <= i_prod_nxt;
    ad_r     <= ad_nxt;
    p_r      <= p_nxt;
    pp_lo_r  <= pp_lo_nxt;
    pp_hi_r  <= pp_hi_nxt;
    i_raw_r  <= i_raw_nxt;
    integ_r  <= integ_nxt;
    ovf_r    <= ovf_nxt;
    mag_r    <= mag_nxt;
    der_r    <= der_nxt;
    sum_r    <= sum_nxt;
  end

  // State update when the result is handed to the merge stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_error_r   <= '0;
      integral_sum_r <= '0;
    end else if (ctrl.commit && on) begin
      prev_error_r   <= e_r;
      integral_sum_r <= integ_r;
    end
  end

  assign drive = on ? sum_r : 32'sd0;

endmodule

`default_nettype wire

// File: rtl/pidaw_merge.sv
// Merge stage: gathers the lane drives into the result register and its handshake.
`default_nettype none

module pidaw_merge import pidaw_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pidaw_ctrl_t        ctrl,
  input  wire logic signed [31:0] drive [LANES_MAX],
  output logic                    space,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pidaw_out_t              out_data
);

  logic       out_valid_r, out_valid_nxt;
  pidaw_out_t out_data_r,  out_data_nxt;

  // The register can take a beat when empty or when its beat leaves now.
  assign space = !out_valid_r || out_ready;

  // Pack the lane drives into one result beat and work out the next valid flag.
  always_comb begin
    out_data_nxt.drive_0 = drive[0];
    out_data_nxt.drive_1 = drive[1];
    out_data_nxt.drive_2 = drive[2];
    out_data_nxt.drive_3 = drive[3];
    out_data_nxt.drive_4 = drive[4];
    if (ctrl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded on commit.
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/multichannel_pid_antiwindup_unit.sv
// Top level of the multichannel PID unit with trapezoidal integral and anti-windup clamp.
`default_nettype none

// Each input beat carries a target and a predicted value for five channels in signed
// Q16.16; the unit returns one beat of five saturated PID drives. The channels run in
// parallel lanes, one per channel up to CHANNELS, and a merge stage packs their drives
// into the result register. An item is held in an input register while the lane pipeline
// works on it; its result is committed to the result register when the pipeline count is
// done and the register has room, and the next item is taken only after that commit, which
// comes later while a finished result waits for out_ready. One item is in work at a time;
// lanes at or above active_channels drive zero and keep their previous error and integral.
// Writes to the configuration registers (active_channels, sample_rate_hz, half_period) are
// always accepted and belong in idle periods; writes to unknown indexes are dropped.
module multichannel_pid_antiwindup_unit import pidaw_pkg::*; #(
  parameter int unsigned CHANNELS = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire pidaw_in_t            in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output pidaw_out_t                out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  // Configuration registers.
  logic [2:0]  active_r;
  logic [19:0] rate_r;
  logic [31:0] half_r;

  // Sequencer and input register.
  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r,  cnt_nxt;
  pidaw_in_t        in_r;
  logic             space;
  pidaw_ctrl_t      ctrl;

  // Per-lane views of the held input beat and the lane drives.
  logic signed [31:0] tgt_w  [LANES_MAX];
  logic signed [31:0] pred_w [LANES_MAX];
  logic signed [31:0] drive_w [LANES_MAX];

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
      rate_r   <= RATE_RESET;
      half_r   <= HALF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ACTIVE_CHANNELS: active_r <= cfg_data[2:0];
        CFG_SAMPLE_RATE_HZ:  rate_r   <= cfg_data[19:0];
        CFG_HALF_PERIOD:     half_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: count the lane pipeline, then commit when the result register has room.
  always_comb begin
    busy_nxt    = busy_r;
    cnt_nxt     = cnt_r;
    ctrl.commit = 1'b0;
    ctrl.active = active_r;
    if (!busy_r) begin
      if (in_valid) begin
        busy_nxt = 1'b1;
        cnt_nxt  = '0;
      end
    end else if (cnt_r != CNT_W'(LATENCY)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (space) begin
      ctrl.commit = 1'b1;
      busy_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Input register, loaded on an accepted beat and held while the lanes work.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // Split the held beat into lanes.
  always_comb begin
    tgt_w[0]  = in_r.target_0;
    tgt_w[1]  = in_r.target_1;
    tgt_w[2]  = in_r.target_2;
    tgt_w[3]  = in_r.target_3;
    tgt_w[4]  = in_r.target_4;
    pred_w[0] = in_r.predicted_0;
    pred_w[1] = in_r.predicted_1;
    pred_w[2] = in_r.predicted_2;
    pred_w[3] = in_r.predicted_3;
    pred_w[4] = in_r.predicted_4;
  end

  // Lanes for the built channels; the rest drive zero.
  for (genvar g = 0; g < LANES_MAX; g++) begin : g_lane
    if (g < CHANNELS) begin : g_on
      pidaw_lane #(
        .LANE (g)
      ) u_lane (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .target         (tgt_w[g]),
        .predicted      (pred_w[g]),
        .sample_rate_hz (rate_r),
        .half_period    (half_r),
        .drive          (drive_w[g])
      );
    end else begin : g_off
      assign drive_w[g] = 32'sd0;
    end
  end

  // Merge stage and result register.
  pidaw_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .drive     (drive_w),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: rtl/pidaw_checker.sv
// Port checker for the multichannel PID unit and the bind that attaches it.
`default_nettype none

module pidaw_checker import pidaw_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire pidaw_out_t           out_data,
  input wire logic                 cfg_valid,
  input wire logic                 cfg_ready
);

  // Reset leaves the unit empty and ready for a beat.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("unit not empty after reset");

  // Only one item is in work: an accepted beat closes the input until its result is out.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // A new result only appears at the end of an item in work.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without an item in work");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // Configuration writes are never refused.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind multichannel_pid_antiwindup_unit pidaw_checker u_pidaw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

`default_nettype wire
